/* src/epd_pkg.sv */
package epd_pkg;

  localparam int SAMPLE_BYTES = 131;
  localparam int HEADER_BYTES = 8;

  localparam int HDR_CNT_W = 4;
  localparam int POS_W     = 8;
  localparam int CHAN_W    = 7;
  localparam int VAL_W     = 12;
  localparam int FRAME_W   = 64;
  localparam int OFFSET_W  = 32;
  localparam int SPP_W     = 16;
  localparam int ERR_W     = 32;
  localparam int CONT_W    = 2;

  localparam int OUT_TDATA_W = 120;
  localparam int OUT_TUSER_W = 2;

  // sample byte slots: the first silent slot and the slots that carry the DAC words
  localparam logic [POS_W-1:0] POS_FIRST_SILENT = 8'd126;
  localparam logic [POS_W-1:0] POS_DAC_ONE      = 8'd128;
  localparam logic [POS_W-1:0] POS_DAC_TWO      = 8'd129;
  localparam logic [POS_W-1:0] POS_DAC_HIGH     = 8'd130;

  localparam logic [CHAN_W-1:0] CHAN_DAC_ONE = 7'd126;
  localparam logic [CHAN_W-1:0] CHAN_DAC_TWO = 7'd127;

  // configuration register indexes
  localparam logic REG_FRAME_OFFSET       = 1'b0;
  localparam logic REG_SAMPLES_PER_PACKET = 1'b1;

  localparam logic [SPP_W-1:0] SPP_RESET = 16'd256;

  // continuity codes
  localparam logic [CONT_W-1:0] CONT_IN_ORDER = 2'd0;
  localparam logic [CONT_W-1:0] CONT_GAP      = 2'd1;
  localparam logic [CONT_W-1:0] CONT_BEHIND   = 2'd2;

  typedef struct packed {
    logic               sample_valid;
    logic [CHAN_W-1:0]  channel;
    logic [VAL_W-1:0]   sample_value;
    logic               header_valid;
    logic [FRAME_W-1:0] frame_number;
    logic [CONT_W-1:0]  continuity;
    logic [ERR_W-1:0]   error_total;
    logic               last_of_run;
  } res_t;

endpackage

/* src/electrode_packet_deframer.sv */
// Order: an accepted byte is registered in the input stage, whose results are then written
//   into the four-entry result queue and are taken from its head, behind any queued results.
// Throughput: one byte per cycle while out_tready holds high; the DAC high byte makes two
//   results, which the queue absorbs and the silent slots drain, so in_tready drops only
//   when the output stalls.
// Reset (rst_n low, synchronous): header phase, counters and holds zero, offset 0, spp 256.
module electrode_packet_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic [0:0]                       in_tuser,   // [0] packet_start
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [6:0] channel, [18:7] sample_value, [82:19] frame_number,
  // [84:83] continuity, [116:85] error_total, [119:117] zero
  output logic [epd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [epd_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] sample_valid, [1] header_valid
  output logic                             out_tlast,  // last_of_run
  // configuration writes
  input  logic                             cfg_wr_en,
  input  logic                             cfg_addr,
  input  logic [31:0]                      cfg_wdata
);
  import epd_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // what the input stage hands to the result stage
  typedef enum logic [1:0] {
    K_NONE,
    K_HEADER,
    K_SAMPLE,
    K_DAC_PAIR
  } kind_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [OFFSET_W-1:0] offset_r;
  logic [SPP_W-1:0]    spp_r;

  // ---------------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------------
  logic [HDR_CNT_W-1:0] hdr_cnt_r,  hdr_cnt_nxt;
  logic [FRAME_W-1:0]   acc_r,      acc_nxt;
  logic [POS_W-1:0]     byte_pos_r, byte_pos_nxt;
  logic [VAL_W-1:0]     dac_one_r,  dac_one_nxt;
  logic [VAL_W-1:0]     dac_two_r,  dac_two_nxt;
  logic [FRAME_W-1:0]   last_frame_r, last_frame_nxt;
  logic [ERR_W-1:0]     err_cnt_r,    err_cnt_nxt;

  // input stage register
  kind_t               s1_kind_r,  s1_kind_nxt;
  logic [FRAME_W-1:0]  s1_frame_r, s1_frame_nxt;
  logic [CHAN_W-1:0]   s1_chan_r,  s1_chan_nxt;
  logic [VAL_W-1:0]    s1_val_r,   s1_val_nxt;
  logic [VAL_W-1:0]    s1_dac2_r,  s1_dac2_nxt;

  // result queue
  res_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r;

  logic              in_acc;
  logic              out_pop;
  logic [QCNT_W-1:0] s1_res;
  logic [1:0]        in_res_max;
  logic [1:0]        push_n;
  res_t              res0, res1;

  logic                 ps;
  logic [7:0]           b;
  logic [HDR_CNT_W-1:0] hc;
  logic [FRAME_W-1:0]   acc;
  logic [POS_W-1:0]     pos;
  logic [POS_W:0]       pos_inc;

  logic [FRAME_W-1:0]   diff;
  logic                 diff_neg;
  logic                 is_gap;
  logic                 is_behind;
  logic [CONT_W-1:0]    cont;

  assign b  = in_tdata;
  assign ps = in_tuser[0];

  // results held in the input stage
  always_comb begin
    unique case (s1_kind_r)
      K_NONE:     s1_res = 3'd0;
      K_DAC_PAIR: s1_res = 3'd2;
      default:    s1_res = 3'd1;
    endcase
  end

  // most results the next byte can make: two only on the DAC high byte of a sample
  assign in_res_max = (hdr_cnt_r == 4'(HEADER_BYTES) && byte_pos_r == POS_DAC_HIGH) ?
                      2'd2 : 2'd1;

  // take a byte only if the queue has room for everything in flight plus its results
  assign in_tready = ({1'b0, q_cnt_r} + {1'b0, s1_res} + {2'b00, in_res_max}) <=
                     4'(QDEPTH);
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = (q_cnt_r != '0);
  assign out_pop    = out_tvalid && out_tready;

  // ---------------------------------------------------------------------------
  // Input stage: header assembly and sample slot decode
  // ---------------------------------------------------------------------------
  always_comb begin
    // packet_start restarts the header from this byte
    hc  = ps ? '0 : hdr_cnt_r;
    acc = ps ? '0 : acc_r;
    pos = ps ? '0 : byte_pos_r;

    hdr_cnt_nxt  = hc;
    acc_nxt      = acc;
    byte_pos_nxt = pos;
    dac_one_nxt  = dac_one_r;
    dac_two_nxt  = dac_two_r;
    s1_kind_nxt  = K_NONE;
    s1_chan_nxt  = '0;
    s1_val_nxt   = '0;
    s1_dac2_nxt  = '0;
    pos_inc      = {1'b0, pos} + 9'd1;

    if (hc < 4'(HEADER_BYTES)) begin
      // little-endian byte lane select
      for (int i = 0; i < HEADER_BYTES; i++) begin
        acc_nxt[i*8 +: 8] = acc[i*8 +: 8] | ((hc[2:0] == 3'(i)) ? b : 8'h00);
      end
      if (hc == 4'(HEADER_BYTES - 1)) begin
        hdr_cnt_nxt  = 4'(HEADER_BYTES);
        byte_pos_nxt = '0;
        s1_kind_nxt  = K_HEADER;
      end else begin
        hdr_cnt_nxt = hc + 4'd1;
      end
    end else begin
      byte_pos_nxt = (pos_inc >= 9'(SAMPLE_BYTES)) ? '0 : pos_inc[POS_W-1:0];
      if (pos < POS_FIRST_SILENT) begin
        s1_kind_nxt = K_SAMPLE;
        s1_chan_nxt = pos[CHAN_W-1:0];
        s1_val_nxt  = {b, 4'b0000};
      end else if (pos == POS_DAC_ONE) begin
        dac_one_nxt = {2'b00, b, 2'b00};
      end else if (pos == POS_DAC_TWO) begin
        dac_two_nxt = {2'b00, b, 2'b00};
      end else if (pos == POS_DAC_HIGH) begin
        // add the two high fields, wrap to 12 bits
        dac_one_nxt = dac_one_r + {b[1:0], 10'b0};
        dac_two_nxt = dac_two_r + {b[3:2], 10'b0};
        s1_kind_nxt = K_DAC_PAIR;
        s1_val_nxt  = dac_one_nxt;
        s1_dac2_nxt = dac_two_nxt;
      end
    end

    s1_frame_nxt = acc_nxt - FRAME_W'(offset_r);
  end

  // ---------------------------------------------------------------------------
  // Result stage: continuity check and result build
  // ---------------------------------------------------------------------------
  always_comb begin
    diff      = s1_frame_r - last_frame_r;
    diff_neg  = diff[FRAME_W-1];
    is_gap    = !diff_neg && (diff > FRAME_W'(spp_r));
    is_behind = !is_gap && (diff_neg || (diff < FRAME_W'(spp_r)));

    if (is_gap) begin
      cont = CONT_GAP;
    end else if (is_behind) begin
      cont = CONT_BEHIND;
    end else begin
      cont = CONT_IN_ORDER;
    end

    last_frame_nxt = last_frame_r;
    err_cnt_nxt    = err_cnt_r;
    res0           = '0;
    res1           = '0;
    push_n         = 2'd0;

    unique case (s1_kind_r)
      K_HEADER: begin
        last_frame_nxt = s1_frame_r;
        if (cont != CONT_IN_ORDER && err_cnt_r != '1) begin
          err_cnt_nxt = err_cnt_r + 32'd1;
        end
        res0.header_valid = 1'b1;
        res0.frame_number = s1_frame_r;
        res0.continuity   = cont;
        res0.error_total  = err_cnt_nxt;
        res0.last_of_run  = 1'b1;
        push_n            = 2'd1;
      end
      K_SAMPLE: begin
        res0.sample_valid = 1'b1;
        res0.channel      = s1_chan_r;
        res0.sample_value = s1_val_r;
        res0.last_of_run  = 1'b1;
        push_n            = 2'd1;
      end
      K_DAC_PAIR: begin
        res0.sample_valid = 1'b1;
        res0.channel      = CHAN_DAC_ONE;
        res0.sample_value = s1_val_r;
        res1.sample_valid = 1'b1;
        res1.channel      = CHAN_DAC_TWO;
        res1.sample_value = s1_dac2_r;
        res1.last_of_run  = 1'b1;
        push_n            = 2'd2;
      end
      default: begin
        push_n = 2'd0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      spp_r        <= SPP_RESET;
      hdr_cnt_r    <= '0;
      acc_r        <= '0;
      byte_pos_r   <= '0;
      dac_one_r    <= '0;
      dac_two_r    <= '0;
      last_frame_r <= '0;
      err_cnt_r    <= '0;
      s1_kind_r    <= K_NONE;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      q_cnt_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_FRAME_OFFSET:       offset_r <= cfg_wdata;
          REG_SAMPLES_PER_PACKET: spp_r    <= cfg_wdata[SPP_W-1:0];
          default:                offset_r <= offset_r;
        endcase
      end

      // advance parse state on every accepted request
      if (in_acc) begin
        hdr_cnt_r  <= hdr_cnt_nxt;
        acc_r      <= acc_nxt;
        byte_pos_r <= byte_pos_nxt;
        dac_one_r  <= dac_one_nxt;
        dac_two_r  <= dac_two_nxt;
        s1_kind_r  <= s1_kind_nxt;
      end else begin
        s1_kind_r  <= K_NONE;
      end

      last_frame_r <= last_frame_nxt;
      err_cnt_r    <= err_cnt_nxt;

      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + QCNT_W'(push_n) - QCNT_W'(out_pop);
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_frame_r <= s1_frame_nxt;
      s1_chan_r  <= s1_chan_nxt;
      s1_val_r   <= s1_val_nxt;
      s1_dac2_r  <= s1_dac2_nxt;
    end
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr_r + 2'd1] <= res1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output mapping
  // ---------------------------------------------------------------------------
  res_t head;
  assign head = q_mem[rd_ptr_r];

  assign out_tdata = {3'b000, head.error_total, head.continuity, head.frame_number,
                      head.sample_value, head.channel};
  assign out_tuser = {head.header_valid, head.sample_valid};
  assign out_tlast = head.last_of_run;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r + s1_res) <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ps) |=> (hdr_cnt_r == 4'd1))
    else $error("packet start did not restart the header");

  a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (err_cnt_r >= $past(err_cnt_r)))
    else $error("error count went down");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r < 8'(SAMPLE_BYTES))
    else $error("byte position out of sample range");

endmodule

/* dv/tb_electrode_packet_deframer.sv */
module tb_electrode_packet_deframer;
  import epd_pkg::*;

  // Input stage plus the four-deep result queue: let this many cycles pass
  // before treating the block as idle.
  localparam int SETTLE_CYCLES = 8;

  // receiver stall patterns
  localparam int RX_OPEN     = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_STARVE   = 2;
  localparam int RX_PERIODIC = 3;

  typedef struct {
    logic [7:0] data_byte;
    logic       packet_start;
  } byte_req_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;   // [7:0] data_byte
  logic [0:0]             in_tuser = '0;   // [0] packet_start
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [6:0] channel, [18:7] sample_value, [82:19] frame_number,
  // [84:83] continuity, [116:85] error_total, [119:117] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;       // [0] sample_valid, [1] header_valid
  logic                   out_tlast;       // last_of_run
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_addr = 1'b0;
  logic [31:0]            cfg_wdata = '0;

  electrode_packet_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectations
  byte_req_t byte_queue[$];
  res_t      pending_results[$];
  int        queued_total = 0;
  int        mismatch_count = 0;
  logic      req_taken = 1'b0;

  // Deframer shadow: configuration and parser state
  logic [OFFSET_W-1:0]  cfg_offset = '0;
  logic [SPP_W-1:0]     cfg_spp = SPP_RESET;
  logic [HDR_CNT_W-1:0] hdr_taken;
  logic [FRAME_W-1:0]   frame_acc;
  logic [FRAME_W-1:0]   prev_frame;
  logic [ERR_W-1:0]     err_count;
  logic [POS_W-1:0]     sample_pos;
  logic [VAL_W-1:0]     dac_one;
  logic [VAL_W-1:0]     dac_two;

  // Raw header number of the last well-formed packet we generated
  logic [FRAME_W-1:0]   hdr_raw = '0;

  // Sender and receiver pacing
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = RX_OPEN;
  int mode_left = 0;
  int rx_tick = 0;

  task automatic queue_sample(input logic [CHAN_W-1:0] chan, input logic [VAL_W-1:0] value,
                              input logic last);
    res_t r;
    r = '0;
    r.sample_valid = 1'b1;
    r.channel      = chan;
    r.sample_value = value;
    r.last_of_run  = last;
    pending_results.push_back(r);
  endtask

  // Advance the shadow parser by one accepted byte and queue what it yields.
  task automatic deframe_byte(input logic [7:0] b, input logic start);
    res_t              r;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] diff;
    logic [CONT_W-1:0]  cont;
    // A flagged byte restarts the header from any state.
    if (start) begin
      hdr_taken  = '0;
      frame_acc  = '0;
      sample_pos = '0;
    end
    if (hdr_taken < HEADER_BYTES) begin
      frame_acc = frame_acc | ({56'd0, b} << (hdr_taken * 8));
      hdr_taken = hdr_taken + 1'b1;
      if (hdr_taken == HEADER_BYTES) begin
        sample_pos = '0;
        frame = frame_acc - {32'd0, cfg_offset};
        // Signed step against the last header: above the expected advance is a gap,
        // below it (backwards included) is behind.
        diff = frame - prev_frame;
        if (!diff[FRAME_W-1] && diff > {48'd0, cfg_spp})
          cont = CONT_GAP;
        else if (diff[FRAME_W-1] || diff < {48'd0, cfg_spp})
          cont = CONT_BEHIND;
        else
          cont = CONT_IN_ORDER;
        if (cont != CONT_IN_ORDER && err_count != '1)
          err_count = err_count + 1'b1;
        prev_frame = frame;
        r = '0;
        r.header_valid = 1'b1;
        r.frame_number = frame;
        r.continuity   = cont;
        r.error_total  = err_count;
        r.last_of_run  = 1'b1;
        pending_results.push_back(r);
      end
    end else begin
      // Slots 126, 127 and anything past 130 stay silent.
      if (sample_pos < POS_FIRST_SILENT) begin
        queue_sample(sample_pos[CHAN_W-1:0], {b, 4'd0}, 1'b1);
      end else if (sample_pos == POS_DAC_ONE) begin
        dac_one = {2'd0, b, 2'd0};
      end else if (sample_pos == POS_DAC_TWO) begin
        dac_two = {2'd0, b, 2'd0};
      end else if (sample_pos == POS_DAC_HIGH) begin
        dac_one = dac_one + {b[1:0], 10'd0};
        dac_two = dac_two + {b[3:2], 10'd0};
        queue_sample(CHAN_DAC_ONE, dac_one, 1'b0);
        queue_sample(CHAN_DAC_TWO, dac_two, 1'b1);
      end
      sample_pos = (sample_pos == SAMPLE_BYTES - 1) ? '0 : sample_pos + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: check taken results, then feed the shadow parser with the taken request.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      req_taken  = 1'b0;
      hdr_taken  = '0;
      frame_acc  = '0;
      prev_frame = '0;
      err_count  = '0;
      sample_pos = '0;
      dac_one    = '0;
      dac_two    = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.sample_valid = out_tuser[0];
        got.header_valid = out_tuser[1];
        got.channel      = out_tdata[6:0];
        got.sample_value = out_tdata[18:7];
        got.frame_number = out_tdata[82:19];
        got.continuity   = out_tdata[84:83];
        got.error_total  = out_tdata[116:85];
        got.last_of_run  = out_tlast;
        if (pending_results.size() == 0) begin
          $error("result with no expectation waiting");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("sample_valid", want.sample_valid, got.sample_valid);
          check_field("channel",      want.channel,      got.channel);
          check_field("sample_value", want.sample_value, got.sample_value);
          check_field("header_valid", want.header_valid, got.header_valid);
          check_field("frame_number", want.frame_number, got.frame_number);
          check_field("continuity",   want.continuity,   got.continuity);
          check_field("error_total",  want.error_total,  got.error_total);
          check_field("last_of_run",  want.last_of_run,  got.last_of_run);
        end
      end
      req_taken = in_tvalid && in_tready;
      if (req_taken)
        deframe_byte(in_tdata, in_tuser[0]);
    end
  end

  // Driver: send requests in bursts with gaps, never dropping a request once raised.
  always @(negedge clk) begin
    if (rst_n) begin
      if (req_taken)
        void'(byte_queue.pop_front());
      if (in_tvalid && !req_taken) begin
        // hold: request still waiting for ready
      end else if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= byte_queue[0].data_byte;
        in_tuser  <= byte_queue[0].packet_start;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          case ($urandom_range(0, 7))
            0: begin
              // long unbroken stretch
              burst_left = $urandom_range(100, 300);
              gap_left   = 0;
            end
            1: begin
              burst_left = 1;
              gap_left   = $urandom_range(1, 3);
            end
            default: begin
              burst_left = $urandom_range(1, 24);
              gap_left   = $urandom_range(0, 6);
            end
          endcase
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switch between stall patterns at random.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
      mode_left  = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    rx_tick++;
    case (stall_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_STARVE: out_tready <= ($urandom_range(0, 5) == 0);
      default:   out_tready <= (rx_tick[2:0] != 3'd7);
    endcase
  end

  task automatic push_byte(input logic [7:0] b, input logic start);
    byte_req_t req;
    req.data_byte    = b;
    req.packet_start = start;
    byte_queue.push_back(req);
    queued_total++;
  endtask

  // Little-endian frame number, first byte flagged.
  task automatic push_header(input logic [FRAME_W-1:0] raw);
    for (int i = 0; i < HEADER_BYTES; i++)
      push_byte(raw[i*8 +: 8], i == 0);
  endtask

  task automatic push_payload(input int count);
    repeat (count) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Mostly well-formed packets; some truncated headers and loose noise bytes.
  task automatic push_packet();
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      push_payload($urandom_range(0, 6));
    end else if (kind == 2) begin
      repeat ($urandom_range(1, 6))
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else begin
      case ($urandom_range(0, 9))
        6:       hdr_raw = hdr_raw + cfg_spp + $urandom_range(1, 1000);
        7:       hdr_raw = hdr_raw - $urandom_range(0, 1000);
        8:       hdr_raw = {$urandom, $urandom};
        9:       hdr_raw = hdr_raw + cfg_spp - 1;
        default: hdr_raw = hdr_raw + cfg_spp;
      endcase
      push_header(hdr_raw);
      case ($urandom_range(0, 9))
        6, 7:    push_payload($urandom_range(131, 140));
        8:       push_payload($urandom_range(141, 270));
        9:       push_payload(0);
        default: push_payload($urandom_range(0, 30));
      endcase
    end
  endtask

  task automatic push_random(input int count);
    int stop_at;
    stop_at = queued_total + count;
    while (queued_total < stop_at)
      push_packet();
  endtask

  // Wait until every request went out and every expected result came back.
  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    if (addr == REG_FRAME_OFFSET)
      cfg_offset = value;
    else
      cfg_spp = value[SPP_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int spins;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: header bytes before any flag (all-ones frame, behind),
    // a truncated header, frame zero with extreme payload bytes,
    // then a restart mid-sample that jumps ahead (gap).
    repeat (HEADER_BYTES) push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b1);
    push_byte(8'hA5, 1'b0);
    push_header(64'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    hdr_raw = 64'd700;
    push_header(hdr_raw);
    push_random(320);
    wait_idle();

    // Largest offset, smallest advance.
    write_reg(REG_FRAME_OFFSET, 32'hFFFF_FFFF);
    write_reg(REG_SAMPLES_PER_PACKET, 32'd1);
    push_random(350);
    wait_idle();

    // Random offset, largest advance.
    write_reg(REG_FRAME_OFFSET, $urandom);
    write_reg(REG_SAMPLES_PER_PACKET, 32'd65535);
    push_random(350);
    wait_idle();

    // Zero offset, random advance; stall mid-packet until the output has drained.
    write_reg(REG_FRAME_OFFSET, 32'd0);
    write_reg(REG_SAMPLES_PER_PACKET, $urandom_range(1, 65535));
    hdr_raw = hdr_raw + cfg_spp;
    push_header(hdr_raw);
    push_payload(40);
    wait_idle();
    push_payload(120);
    push_random(280);
    wait_idle();

    write_reg(REG_FRAME_OFFSET, $urandom);
    write_reg(REG_SAMPLES_PER_PACKET, $urandom_range(1, 65535));
    push_random(350);

    // Drain: give leftover results a bounded time to show up.
    while (byte_queue.size() != 0 || in_tvalid)
      @(posedge clk);
    spins = 0;
    while (pending_results.size() != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("electrode_packet_deframer verification clean");
    end else begin
      $display("electrode_packet_deframer verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("electrode_packet_deframer verification failed");
    $finish;
  end

endmodule
